// File: hw/rtl/arn_pkg.sv
package arn_pkg;

	// Sample and fraction widths of the normalizer.
	localparam int SAMPLE_BITS   = 8;
	localparam int FRACTION_BITS = 15;
	localparam int OUT_BITS      = 16;

	// The quotient never exceeds 1.0, so one integer bit above the fraction suffices.
	localparam int QUO_W  = FRACTION_BITS + 1;
	localparam int STEPS  = QUO_W;
	localparam int CNT_W  = $clog2(STEPS);
	localparam int REM_W  = SAMPLE_BITS + 1;
	localparam int WIDE_W = (QUO_W + 1 > OUT_BITS) ? QUO_W + 1 : OUT_BITS;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SAMPLE_BITS-1:0]        mag_t;
	typedef logic [QUO_W-1:0]              quo_t;
	typedef logic signed [OUT_BITS-1:0]    scaled_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DIV  = 2'b10
	} state_t;

endpackage

// File: hw/rtl/arn_if.sv
interface arn_in_if;
	logic              valid;
	logic              ready;
	logic              axis_select;
	arn_pkg::sample_t  position;

	modport source (output valid, output axis_select, output position, input ready);
	modport sink   (input valid, input axis_select, input position, output ready);
endinterface

interface arn_out_if;
	logic              valid;
	logic              ready;
	arn_pkg::scaled_t  scaled_position;

	modport source (output valid, output scaled_position, input ready);
	modport sink   (input valid, input scaled_position, output ready);
endinterface

// File: hw/rtl/auto_ranging_axis_normalizer.sv
// The restoring divider yields one quotient bit per step, and a result is offered once the last step is done.
// The shared compare-and-subtract unit of the divider works on one sample at a time, and the input is not ready
// until the sample is finished; the final step also waits until the output register is free.
// A finished result waits in the output register while the next sample is taken.
// Reset (arst_n low, asynchronous) sets both axis maxima to +1, both minima to -1,
// and empties the block.
module auto_ranging_axis_normalizer (
	input  logic          clk,
	input  logic          arst_n,
	arn_in_if.sink        sample,
	arn_out_if.source     result
);

	localparam arn_pkg::sample_t PEAK_POS_ONE = arn_pkg::sample_t'(1);
	localparam arn_pkg::sample_t PEAK_NEG_ONE = arn_pkg::sample_t'(-1);

	// Running extremes, one entry per axis (0 = X, 1 = Y).
	arn_pkg::sample_t peak_high_q [2];
	arn_pkg::sample_t peak_low_q  [2];

	arn_pkg::state_t           state_q;
	logic [arn_pkg::CNT_W-1:0] step_q;
	logic                      neg_q;
	arn_pkg::mag_t             den_q;
	logic [arn_pkg::REM_W-1:0] rem_q;
	arn_pkg::quo_t             quo_q;
	logic                      out_valid_q;
	arn_pkg::scaled_t          out_data_q;

	// Front end: widen the selected axis's extremes, then pick numerator and
	// divisor magnitudes. After widening the sample never lies outside its
	// extremes, so the quotient is at most 1.0.
	arn_pkg::sample_t                  cur_high;
	arn_pkg::sample_t                  cur_low;
	arn_pkg::sample_t                  new_high;
	arn_pkg::sample_t                  new_low;
	logic                              pos_positive;
	logic signed [arn_pkg::SAMPLE_BITS:0] neg_pos;
	logic signed [arn_pkg::SAMPLE_BITS:0] neg_low;
	arn_pkg::mag_t                     num_mag;
	arn_pkg::mag_t                     den_mag;
	logic                              in_xfer;

	always_comb begin
		cur_high     = peak_high_q[sample.axis_select];
		cur_low      = peak_low_q[sample.axis_select];
		new_high     = (sample.position > cur_high) ? sample.position : cur_high;
		new_low      = (sample.position < cur_low) ? sample.position : cur_low;
		pos_positive = (sample.position > arn_pkg::sample_t'(0));
		neg_pos      = -{sample.position[arn_pkg::SAMPLE_BITS-1], sample.position};
		neg_low      = -{new_low[arn_pkg::SAMPLE_BITS-1], new_low};
		if (pos_positive) begin
			num_mag = arn_pkg::mag_t'(sample.position);
			den_mag = arn_pkg::mag_t'(new_high);
		end else begin
			num_mag = neg_pos[arn_pkg::SAMPLE_BITS-1:0];
			den_mag = neg_low[arn_pkg::SAMPLE_BITS-1:0];
		end
	end

	assign sample.ready = (state_q == arn_pkg::ST_IDLE);
	assign in_xfer      = sample.valid && sample.ready;

	// Shared divider step: compare the partial remainder with the divisor and
	// subtract when it fits. Each step yields one quotient bit, MSB first.
	logic [arn_pkg::REM_W-1:0] den_ext;
	logic                      quo_bit;
	logic [arn_pkg::REM_W-1:0] rem_next;
	logic                      last_step;
	arn_pkg::quo_t             quo_final;
	logic [arn_pkg::WIDE_W-1:0] quo_wide;
	logic [arn_pkg::WIDE_W-1:0] res_wide;
	logic                      out_free;

	always_comb begin
		den_ext   = {1'b0, den_q};
		quo_bit   = (rem_q >= den_ext);
		rem_next  = quo_bit ? (rem_q - den_ext) : rem_q;
		last_step = (step_q == arn_pkg::CNT_W'(arn_pkg::STEPS - 1));
		quo_final = {quo_q[arn_pkg::QUO_W-2:0], quo_bit};
		quo_wide  = arn_pkg::WIDE_W'(quo_final);
		if (neg_q) begin
			// Minus one is representable, so the negative side needs no clamp.
			res_wide = -quo_wide;
		end else if (quo_final[arn_pkg::QUO_W-1]) begin
			// Exactly plus one saturates to the largest fraction.
			res_wide = (arn_pkg::WIDE_W'(1) << arn_pkg::FRACTION_BITS) - arn_pkg::WIDE_W'(1);
		end else begin
			res_wide = quo_wide;
		end
		out_free = !out_valid_q || result.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= arn_pkg::ST_IDLE;
			step_q         <= '0;
			out_valid_q    <= 1'b0;
			peak_high_q[0] <= PEAK_POS_ONE;
			peak_high_q[1] <= PEAK_POS_ONE;
			peak_low_q[0]  <= PEAK_NEG_ONE;
			peak_low_q[1]  <= PEAK_NEG_ONE;
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				arn_pkg::ST_IDLE: begin
					if (in_xfer) begin
						peak_high_q[sample.axis_select] <= new_high;
						peak_low_q[sample.axis_select]  <= new_low;
						step_q  <= '0;
						state_q <= arn_pkg::ST_DIV;
					end
				end
				arn_pkg::ST_DIV: begin
					if (!last_step) begin
						step_q <= step_q + arn_pkg::CNT_W'(1);
					end else if (out_free) begin
						// The final step waits until the output register can take the result.
						out_valid_q <= 1'b1;
						state_q     <= arn_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= arn_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			neg_q <= !pos_positive;
			den_q <= den_mag;
			rem_q <= {1'b0, num_mag};
			quo_q <= '0;
		end else if (state_q == arn_pkg::ST_DIV && !last_step) begin
			rem_q <= {rem_next[arn_pkg::REM_W-2:0], 1'b0};
			quo_q <= quo_final;
		end
		if (state_q == arn_pkg::ST_DIV && last_step && out_free) begin
			out_data_q <= arn_pkg::scaled_t'(res_wide[arn_pkg::OUT_BITS-1:0]);
		end
	end

	assign result.valid           = out_valid_q;
	assign result.scaled_position = out_data_q;

endmodule

// File: bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// The scoreboard keeps its own copy of the per-axis extremes and works out the
	// normalized value of every sample that the block accepts. Results are expected
	// strictly in the order of the sample transfers.
	class scaled_position_scoreboard;
		localparam int UNITY = 1 << arn_pkg::FRACTION_BITS;

		arn_pkg::sample_t peak_high[2];
		arn_pkg::sample_t peak_low[2];
		arn_pkg::scaled_t expected_q[$];
		int               failures;

		function new();
			peak_high[0] = arn_pkg::sample_t'(1);
			peak_high[1] = arn_pkg::sample_t'(1);
			peak_low[0]  = arn_pkg::sample_t'(-1);
			peak_low[1]  = arn_pkg::sample_t'(-1);
			failures     = 0;
		endfunction

		// Widens the selected axis's range, then scales the sample against it.
		function arn_pkg::scaled_t scale_sample(logic ax, arn_pkg::sample_t pos);
			int num;
			int den;
			int quo;
			if (pos > peak_high[ax])
				peak_high[ax] = pos;
			if (pos < peak_low[ax])
				peak_low[ax] = pos;
			if (pos > 0) begin
				num = int'(pos);
				den = int'(peak_high[ax]);
				quo = (num << arn_pkg::FRACTION_BITS) / den;
				if (quo > UNITY - 1)
					quo = UNITY - 1;
				return arn_pkg::scaled_t'(quo);
			end
			num = -int'(pos);
			den = -int'(peak_low[ax]);
			quo = (num << arn_pkg::FRACTION_BITS) / den;
			if (quo > UNITY)
				quo = UNITY;
			return arn_pkg::scaled_t'(-quo);
		endfunction

		function void note_sample(logic ax, arn_pkg::sample_t pos);
			expected_q.push_back(scale_sample(ax, pos));
		endfunction

		function void check_result(arn_pkg::scaled_t actual);
			arn_pkg::scaled_t want;
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("ERROR: scaled_position %0d arrived with nothing expected",
						actual);
				return;
			end
			want = expected_q.pop_front();
			if (actual !== want) begin
				failures++;
				if (failures <= 10)
					$display("ERROR: scaled_position expected %0d (0x%h), got %0d (0x%h)",
						want, want, actual, actual);
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		// Anything still expected at the very end is a result that never came.
		function int close_out();
			failures += expected_q.size();
			return failures;
		endfunction
	endclass

	logic clk;
	logic arst_n;

	arn_in_if  sample_ch();
	arn_out_if result_ch();

	auto_ranging_axis_normalizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	scaled_position_scoreboard board = new();

	// Idle probabilities in percent for the sample sender and the result receiver.
	int send_idle_pct = 15;
	int recv_idle_pct = 80;

	// A long receiver hold-off is requested by the stimulus process and counted
	// down by the receiver process itself.
	int hold_request = 0;
	int hold_left    = 0;

	// Directed samples. The first few run against the reset extremes of +1 and -1,
	// so a sample of +1 must saturate to the largest positive code and -1 must
	// come out as exactly minus one. Zero samples must leave the range alone.
	// The full-scale extremes are only used on the X axis so that the Y axis
	// still has a narrow range when the random ramp below starts.
	logic             directed_axis[22] = '{
		1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0
	};
	arn_pkg::sample_t directed_pos[22] = '{
		8'sd1, -8'sd1, 8'sd0, 8'sd0, -8'sd1, 8'sd1, 8'sd2, 8'sd1, -8'sd2, -8'sd1, 8'sd0,
		8'sd127, -8'sd128, 8'sd63, -8'sd64, 8'sd1, -8'sd1, 8'sd126, 8'sd2, -8'sd2,
		-8'sd127, 8'sd0
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one sample and returns at the edge where the transfer happens. The
	// valid line is only lowered when the sender decides to idle, so back-to-back
	// samples keep valid high without a glitch in between.
	task automatic send_sample(input logic ax, input arn_pkg::sample_t pos);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.axis_select <= ax;
		sample_ch.position    <= pos;
		do
			@(posedge clk);
		while (sample_ch.ready !== 1'b1);
		board.note_sample(ax, pos);
	endtask

	// Result receiver. The output is sampled at the rising edge, before anything
	// driven at that edge takes effect, and ready is then redrawn for the next cycle.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
				board.check_result(result_ch.scaled_position);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int   bound;
		int   val;
		logic ax;

		arst_n                <= 1'b0;
		sample_ch.valid       <= 1'b0;
		sample_ch.axis_select <= 1'b0;
		sample_ch.position    <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_pos[i])
			send_sample(directed_axis[i], directed_pos[i]);

		for (int n = 0; n < 1800; n++) begin
			// Second third: the sender is now the slow side.
			if (n == 600) begin
				send_idle_pct = 80;
				recv_idle_pct = 15;
			end
			// Last third: no idling at all, but it opens with a long receiver
			// hold-off while samples keep coming, so the block backs up and
			// drops its input ready.
			if (n == 1200) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_request  = 400;
			end

			if (n < 400) begin
				// The Y range is still narrow here. Its bound grows by at most one per sample,
				// so the extremes widen gradually and many divisors get used.
				bound = 2 + (n * 126) / 400;
				val   = int'($urandom_range(2 * bound)) - bound;
				if (val > 127)
					val = 127;
				send_sample(1'b1, arn_pkg::sample_t'(val));
			end else begin
				ax = 1'($urandom_range(1));
				if ($urandom_range(9) == 0) begin
					case ($urandom_range(4))
						0:       val = 127;
						1:       val = -128;
						2:       val = 0;
						3:       val = 1;
						default: val = -1;
					endcase
				end else begin
					val = int'($urandom_range(255)) - 128;
				end
				send_sample(ax, arn_pkg::sample_t'(val));
			end
		end
		sample_ch.valid <= 1'b0;

		// Drain: wait for every expected result, then allow a little more than
		// the block's latency for anything spurious to show up.
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (board.close_out() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of roughly 1800 samples.
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/arn_pkg.sv
hw/rtl/arn_if.sv
hw/rtl/auto_ranging_axis_normalizer.sv
bench/tb_top.sv
